// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every assertion samples on the rising
// edge of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define ASSERT_SAME_CYCLE(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Whenever the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT_CYCLE(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and fixed constants of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int OP_BITS        = 2;
   localparam int CFG_BITS       = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SUM_BITS       = 40;

   localparam logic [OP_BITS-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_COMPUTE = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS_OF_A  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLS_OF_B  = 2'd2;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

   // Command word from the controller to the datapath.
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic issue;
      logic first_k;
      logic last_k;
      logic last_elem;
   } ctrl_cmd_type;

endpackage

// ===== rtl/core/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mme_csr.sv =====
// ----------------------------------------------------------------------------
// mme_csr
// Size registers; presents each size as the last loop index, clamped to range.
// ----------------------------------------------------------------------------
module mme_csr import mme_pkg::*; #(
   parameter int MAX_DIM = 8,
   localparam int IDX_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CFG_BITS-1:0]       wr_data,
   output logic [IDX_BITS-1:0]       last_i,
   output logic [IDX_BITS-1:0]       last_k,
   output logic [IDX_BITS-1:0]       last_j
);

   logic [CFG_BITS-1:0] rows_ff, rows_in;
   logic [CFG_BITS-1:0] inner_ff, inner_in;
   logic [CFG_BITS-1:0] cols_ff, cols_in;

   // A size of zero counts as one, and a size above the maximum as the maximum.
   function automatic logic [IDX_BITS-1:0] last_index(input logic [CFG_BITS-1:0] v);
      logic [IDX_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_DIM) begin
         r = IDX_BITS'(MAX_DIM - 1);
      end else begin
         r = IDX_BITS'(int'(v) - 1);
      end
      return r;
   endfunction

   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_ROWS_OF_A:  rows_in  = wr_data;
            CSR_INNER_SIZE: inner_in = wr_data;
            CSR_COLS_OF_B:  cols_in  = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= CFG_RESET;
         inner_ff <= CFG_RESET;
         cols_ff  <= CFG_RESET;
      end else begin
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
      end
   end

   assign last_i = last_index(rows_ff);
   assign last_k = last_index(inner_ff);
   assign last_j = last_index(cols_ff);

endmodule

// ===== rtl/core/mme_ctrl.sv =====
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller: takes items, walks the row, column and inner loops and drains.
// ----------------------------------------------------------------------------
module mme_ctrl import mme_pkg::*; #(
   parameter int MAX_DIM = 8,
   localparam int IDX_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OP_BITS-1:0]  operation,
   input  logic [IDX_BITS-1:0] last_i,
   input  logic [IDX_BITS-1:0] last_k,
   input  logic [IDX_BITS-1:0] last_j,
   input  logic                pipe_idle,
   output logic                busy,
   output ctrl_cmd_type        cmd,
   output logic [IDX_BITS-1:0] idx_i,
   output logic [IDX_BITS-1:0] idx_j,
   output logic [IDX_BITS-1:0] idx_k
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] i_ff, i_in;
   logic [IDX_BITS-1:0] j_ff, j_in;
   logic [IDX_BITS-1:0] k_ff, k_in;
   logic                accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (operation == OP_COMPUTE)) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (k_ff != last_k) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (j_ff != last_j) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  if (i_ff != last_i) begin
                     i_in = i_ff + 1'b1;
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (pipe_idle) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      cmd.load_a    = accept && (operation == OP_LOAD_A);
      cmd.load_b    = accept && (operation == OP_LOAD_B);
      cmd.issue     = (state_ff == ST_RUN);
      cmd.first_k   = (k_ff == '0);
      cmd.last_k    = (k_ff == last_k);
      cmd.last_elem = (i_ff == last_i) && (j_ff == last_j);
   end

   assign busy  = (state_ff != ST_IDLE);
   assign idx_i = i_ff;
   assign idx_j = j_ff;
   assign idx_k = k_ff;

endmodule

// ===== rtl/core/mme_datapath.sv =====
// ----------------------------------------------------------------------------
// mme_datapath
// Element stores, multiplier and accumulator with the result registers.
// ----------------------------------------------------------------------------
module mme_datapath import mme_pkg::*; #(
   parameter int MAX_DIM      = 8,
   parameter int ELEMENT_BITS = 16,
   localparam int IDX_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_cmd_type                   cmd,
   input  logic [IDX_BITS-1:0]            idx_i,
   input  logic [IDX_BITS-1:0]            idx_j,
   input  logic [IDX_BITS-1:0]            idx_k,
   input  logic [IDX_BITS-1:0]            load_row,
   input  logic [IDX_BITS-1:0]            load_col,
   input  logic signed [ELEMENT_BITS-1:0] load_value,
   output logic                           pipe_idle,
   output logic                           rsp_valid,
   output logic [IDX_BITS-1:0]            rsp_row,
   output logic [IDX_BITS-1:0]            rsp_col,
   output logic signed [SUM_BITS-1:0]     rsp_value,
   output logic                           rsp_last
);

   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_BITS = 2 * ELEMENT_BITS;

   logic                    in_range;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [ADDR_BITS-1:0]    a_addr;
   logic [ADDR_BITS-1:0]    b_addr;
   logic [ELEMENT_BITS-1:0] a_rd;
   logic [ELEMENT_BITS-1:0] b_rd;

   // Stage 1: store read data arrives.
   logic                s1_valid_ff;
   logic                s1_first_ff, s1_last_k_ff, s1_last_elem_ff;
   logic [IDX_BITS-1:0] s1_i_ff, s1_j_ff;
   // Stage 2: product registered.
   logic                        s2_valid_ff;
   logic                        s2_first_ff, s2_last_k_ff, s2_last_elem_ff;
   logic [IDX_BITS-1:0]         s2_i_ff, s2_j_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   // Stage 3: running sum and result tags.
   logic signed [SUM_BITS-1:0]  acc_ff, acc_in;
   logic signed [SUM_BITS-1:0]  prod_ext;
   logic                        rsp_valid_ff;
   logic                        rsp_last_ff;
   logic [IDX_BITS-1:0]         rsp_row_ff, rsp_col_ff;

   // Loads outside the store are dropped; only possible when MAX_DIM is one or not a power of two.
   assign in_range = ({1'b0, load_row} < (IDX_BITS + 1)'(MAX_DIM))
                  && ({1'b0, load_col} < (IDX_BITS + 1)'(MAX_DIM));

   assign wr_addr = ADDR_BITS'(int'(load_row) * MAX_DIM + int'(load_col));
   assign a_addr  = ADDR_BITS'(int'(idx_i) * MAX_DIM + int'(idx_k));
   assign b_addr  = ADDR_BITS'(int'(idx_k) * MAX_DIM + int'(idx_j));

   mme_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (cmd.load_a && in_range),
      .wr_addr (wr_addr),
      .wr_data (load_value),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   mme_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (cmd.load_b && in_range),
      .wr_addr (wr_addr),
      .wr_data (load_value),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   assign prod_in  = $signed(a_rd) * $signed(b_rd);
   // The product is sign-extended, or wrapped, into the width of the sum.
   assign prod_ext = SUM_BITS'(prod_ff);
   assign acc_in   = s2_first_ff ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_last_k_ff;
         if (s2_valid_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff     <= cmd.first_k;
      s1_last_k_ff    <= cmd.last_k;
      s1_last_elem_ff <= cmd.last_elem;
      s1_i_ff         <= idx_i;
      s1_j_ff         <= idx_j;

      prod_ff         <= prod_in;
      s2_first_ff     <= s1_first_ff;
      s2_last_k_ff    <= s1_last_k_ff;
      s2_last_elem_ff <= s1_last_elem_ff;
      s2_i_ff         <= s1_i_ff;
      s2_j_ff         <= s1_j_ff;

      rsp_last_ff     <= s2_last_elem_ff;
      rsp_row_ff      <= s2_i_ff;
      rsp_col_ff      <= s2_j_ff;
   end

   assign pipe_idle = !s1_valid_ff && !s2_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_value = acc_ff;
   assign rsp_last  = rsp_valid_ff && rsp_last_ff;

endmodule

// ===== rtl/core/matrix_multiply_engine_unit.sv =====
// A load word is written in the cycle it is taken and busy stays low.
// A compute word keeps busy high until the loops are done and the pipeline has drained;
// one result comes out per row and column pair, row by row, as its inner loop ends,
// with one product a cycle through a single MAC unit.
// Synchronous active-high reset sets every size to 8 and clears the running sum;
// the element stores are undefined until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit
// General matrix multiply R = A * B over signed Q8.8 elements, exact Q24.16 sums.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_multiply_engine_unit import mme_pkg::*; #(
   parameter int MAX_DIM      = 8,
   parameter int ELEMENT_BITS = 16,
   localparam int IDX_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [OP_BITS-1:0]             req_operation,
   input  logic [IDX_BITS-1:0]            req_row_index,
   input  logic [IDX_BITS-1:0]            req_col_index,
   input  logic signed [ELEMENT_BITS-1:0] req_element_value,
   output logic                           rsp_valid,
   output logic [IDX_BITS-1:0]            rsp_result_row,
   output logic [IDX_BITS-1:0]            rsp_result_col,
   output logic signed [SUM_BITS-1:0]     rsp_result_value,
   output logic                           rsp_last_result,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [CFG_BITS-1:0]            csr_data
);

   ctrl_cmd_type        cmd;
   logic                pipe_idle;
   logic                compute_taken;
   logic [IDX_BITS-1:0] last_i, last_k, last_j;
   logic [IDX_BITS-1:0] idx_i, idx_j, idx_k;

   // Sizes may only change while no product is being formed.
   assign csr_ready = !busy;

   assign compute_taken = start && !busy && (req_operation == OP_COMPUTE);

   mme_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .last_i   (last_i),
      .last_k   (last_k),
      .last_j   (last_j)
   );

   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .last_i    (last_i),
      .last_k    (last_k),
      .last_j    (last_j),
      .pipe_idle (pipe_idle),
      .busy      (busy),
      .cmd       (cmd),
      .idx_i     (idx_i),
      .idx_j     (idx_j),
      .idx_k     (idx_k)
   );

   mme_datapath #(
      .MAX_DIM      (MAX_DIM),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .idx_i      (idx_i),
      .idx_j      (idx_j),
      .idx_k      (idx_k),
      .load_row   (req_row_index),
      .load_col   (req_col_index),
      .load_value (req_element_value),
      .pipe_idle  (pipe_idle),
      .rsp_valid  (rsp_valid),
      .rsp_row    (rsp_result_row),
      .rsp_col    (rsp_result_col),
      .rsp_value  (rsp_result_value),
      .rsp_last   (rsp_last_result)
   );

   `ASSERT_SAME_CYCLE(a_rsp_only_when_busy, rsp_valid, busy, "result word while not busy")
   `ASSERT_NEXT_CYCLE(a_compute_sets_busy, compute_taken, busy, "compute did not raise busy")
   `ASSERT_NEXT_CYCLE(a_nothing_after_last, rsp_valid && rsp_last_result, !rsp_valid, "word after last")

endmodule
